>>> rtl/core/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared sizes, types, operation and status codes, and index helpers for the
// double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int OP_W       = 3;
    localparam int ST_W       = 2;

    typedef logic        [IDX_W-1:0]      t_idx;
    typedef logic        [CNT_W-1:0]      t_cnt;
    typedef logic signed [DATA_WIDTH-1:0] t_word;
    typedef logic        [OP_W-1:0]       t_op;
    typedef logic        [ST_W-1:0]       t_status;

    // Operation codes; the unused codes act as no operation
    localparam t_op OP_NONE       = 3'd0;
    localparam t_op OP_PUSH_FRONT = 3'd1;
    localparam t_op OP_PUSH_BACK  = 3'd2;
    localparam t_op OP_POP_FRONT  = 3'd3;
    localparam t_op OP_POP_BACK   = 3'd4;

    // Status codes
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_UNDERFLOW = 2'd1;
    localparam t_status ST_OVERFLOW  = 2'd2;

    localparam t_cnt CNT_FULL = CNT_W'(DEPTH);

    // Step a ring index forward, wrapping at the last entry
    function automatic t_idx idx_inc(input t_idx i);
        t_idx r;
        if (i == IDX_W'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = i + IDX_W'(1);
        end
        return r;
    endfunction

    // Step a ring index back, wrapping at entry zero
    function automatic t_idx idx_dec(input t_idx i);
        t_idx r;
        if (i == '0) begin
            r = IDX_W'(DEPTH - 1);
        end else begin
            r = i - IDX_W'(1);
        end
        return r;
    endfunction

endpackage

>>> rtl/core/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed words in a ring RAM with head and tail indexes,
// a word count and cached front and rear words.
// ----------------------------------------------------------------------------
// Each accepted word carries one operation (none, push front, push back, pop
// front, pop back) and yields one result word with the popped value, the new
// front and rear values (all ones when empty), the count, an empty flag and a
// status (underflow on a pop from empty, overflow on a push to full; either
// leaves the deque unchanged). Pushes, no-ops, failed pops and pops that
// leave the deque empty load the result register from the idle state. A
// pop that leaves words behind goes through the read state while the ring
// RAM fetches the new front or rear word. A new word is taken as soon as
// the block is idle and the result register is free or being drained. No
// clearing pass is needed after reset.
module double_ended_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  deq_pkg::t_op           i_operation,
    input  deq_pkg::t_word         i_data_in,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output deq_pkg::t_word         o_popped_value,
    output deq_pkg::t_word         o_front_value,
    output deq_pkg::t_word         o_rear_value,
    output deq_pkg::t_cnt          o_item_count,
    output logic                   o_is_empty,
    output deq_pkg::t_status       o_status
);

    import deq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state  r_state, n_state;
    t_idx    r_head, n_head;
    t_idx    r_tail, n_tail;
    t_cnt    r_count, n_count;
    t_word   r_front, n_front;
    t_word   r_rear, n_rear;
    logic    r_pend_front, n_pend_front;
    t_word   r_pend_popped, n_pend_popped;

    logic    r_out_valid, n_out_valid;
    t_word   r_out_popped;
    t_word   r_out_front;
    t_word   r_out_rear;
    t_cnt    r_out_count;
    logic    r_out_empty;
    t_status r_out_status;

    logic    in_acc;
    logic    is_empty_now;
    logic    is_full_now;
    logic    load_out;
    t_word   s_popped;
    t_status s_status;

    logic    mem_we;
    t_idx    mem_waddr;
    logic    mem_re;
    t_idx    mem_raddr;
    t_word   mem_rdata;

    // Ring storage
    deq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_data_in),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Hold input while a pop is fetching or the result register is stuck
    assign o_in_stall   = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign in_acc       = i_in_valid && !o_in_stall;
    assign is_empty_now = (r_count == '0);
    assign is_full_now  = (r_count == CNT_FULL);

    // Apply the operation and sequence the RAM access
    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_tail        = r_tail;
        n_count       = r_count;
        n_front       = r_front;
        n_rear        = r_rear;
        n_pend_front  = r_pend_front;
        n_pend_popped = r_pend_popped;
        n_out_valid   = r_out_valid && i_out_stall;
        mem_we        = 1'b0;
        mem_waddr     = r_head;
        mem_re        = 1'b0;
        mem_raddr     = r_head;
        load_out      = 1'b0;
        s_popped      = '0;
        s_status      = ST_OK;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    load_out = 1'b1;
                    case (i_operation)
                        OP_PUSH_FRONT: begin
                            if (is_full_now) begin
                                s_status = ST_OVERFLOW;
                            end else begin
                                n_head    = idx_dec(r_head);
                                mem_we    = 1'b1;
                                mem_waddr = idx_dec(r_head);
                                n_front   = i_data_in;
                                n_count   = r_count + CNT_W'(1);
                                if (is_empty_now) begin
                                    n_rear = i_data_in;
                                    n_tail = idx_dec(r_head);
                                end
                            end
                        end
                        OP_PUSH_BACK: begin
                            if (is_full_now) begin
                                s_status = ST_OVERFLOW;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = is_empty_now ? r_head : idx_inc(r_tail);
                                n_tail    = mem_waddr;
                                n_rear    = i_data_in;
                                n_count   = r_count + CNT_W'(1);
                                if (is_empty_now) begin
                                    n_front = i_data_in;
                                end
                            end
                        end
                        OP_POP_FRONT: begin
                            if (is_empty_now) begin
                                s_status = ST_UNDERFLOW;
                            end else begin
                                s_popped = r_front;
                                n_head   = idx_inc(r_head);
                                n_count  = r_count - CNT_W'(1);
                                if (r_count != CNT_W'(1)) begin
                                    // fetch the new front word
                                    mem_re        = 1'b1;
                                    mem_raddr     = idx_inc(r_head);
                                    n_pend_front  = 1'b1;
                                    n_pend_popped = r_front;
                                    n_state       = S_READ;
                                    load_out      = 1'b0;
                                end
                            end
                        end
                        OP_POP_BACK: begin
                            if (is_empty_now) begin
                                s_status = ST_UNDERFLOW;
                            end else begin
                                s_popped = r_rear;
                                n_tail   = idx_dec(r_tail);
                                n_count  = r_count - CNT_W'(1);
                                if (r_count != CNT_W'(1)) begin
                                    // fetch the new rear word
                                    mem_re        = 1'b1;
                                    mem_raddr     = idx_dec(r_tail);
                                    n_pend_front  = 1'b0;
                                    n_pend_popped = r_rear;
                                    n_state       = S_READ;
                                    load_out      = 1'b0;
                                end
                            end
                        end
                        default: begin
                            s_status = ST_OK;
                        end
                    endcase
                end
            end
            S_READ: begin
                // RAM data is back: refresh the cached end and post the result
                if (r_pend_front) begin
                    n_front = mem_rdata;
                end else begin
                    n_rear = mem_rdata;
                end
                s_popped = r_pend_popped;
                s_status = ST_OK;
                load_out = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (load_out) begin
            n_out_valid = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Cached end words and pending pop
    always_ff @(posedge i_clk) begin
        r_front       <= n_front;
        r_rear        <= n_rear;
        r_pend_front  <= n_pend_front;
        r_pend_popped <= n_pend_popped;
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_popped <= s_popped;
            r_out_count  <= n_count;
            r_out_status <= s_status;
            r_out_empty  <= (n_count == '0);
            r_out_front  <= (n_count == '0) ? '1 : n_front;
            r_out_rear   <= (n_count == '0) ? '1 : n_rear;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_popped_value = r_out_popped;
    assign o_front_value  = r_out_front;
    assign o_rear_value   = r_out_rear;
    assign o_item_count   = r_out_count;
    assign o_is_empty     = r_out_empty;
    assign o_status       = r_out_status;

endmodule

>>> rtl/core/deq_checker.sv
// ----------------------------------------------------------------------------
// deq_port_checks
// Port-level checks on the double-ended queue result words, bound to the
// top level.
// ----------------------------------------------------------------------------
module deq_port_checks (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input deq_pkg::t_word     o_popped_value,
    input deq_pkg::t_word     o_front_value,
    input deq_pkg::t_word     o_rear_value,
    input deq_pkg::t_cnt      o_item_count,
    input logic               o_is_empty,
    input deq_pkg::t_status   o_status
);

    import deq_pkg::*;

    // Empty flag agrees with the count
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_empty == (o_item_count == '0)))
        else $error("empty flag disagrees with item count");

    // Empty deque reports all-ones ends
    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_empty) |-> ((o_front_value == '1) && (o_rear_value == '1)))
        else $error("empty deque shows stored end words");

    // Underflow leaves an empty deque and pops nothing
    a_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_UNDERFLOW)) |-> (o_is_empty && (o_popped_value == '0)))
        else $error("underflow on a non-empty deque");

    // Overflow only on a full deque, and the count never exceeds the depth
    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_item_count <= CNT_FULL) &&
                         ((o_status != ST_OVERFLOW) || (o_item_count == CNT_FULL))))
        else $error("count out of range or overflow below full");

    // Stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_popped_value) &&
                                          $stable(o_item_count)))
        else $error("stalled result word changed");

endmodule

bind double_ended_queue deq_port_checks u_deq_checker (.*);

>>> tb/deq_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deq_checker
// Watches both channels of the double-ended queue, keeps its own copy of the
// ring (head, count, stored words), predicts one result word per accepted
// operation and compares every accepted result word, field by field, with
// the oldest prediction still due.
// ----------------------------------------------------------------------------
module deq_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  deq_pkg::t_op     i_operation,
    input  deq_pkg::t_word   i_data_in,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  deq_pkg::t_word   i_popped_value,
    input  deq_pkg::t_word   i_front_value,
    input  deq_pkg::t_word   i_rear_value,
    input  deq_pkg::t_cnt    i_item_count,
    input  logic             i_is_empty,
    input  deq_pkg::t_status i_status,
    output int               o_mismatch_count,
    output int               o_pending
);

    import deq_pkg::*;

    typedef struct packed {
        t_word   popped;
        t_word   front;
        t_word   rear;
        t_cnt    count;
        logic    empty;
        t_status status;
    } t_deq_outcome;

    // Shadow deque: ring words, front position and word count
    t_word       ring_words [DEPTH];
    int unsigned front_idx  = 0;
    int unsigned word_count = 0;

    t_deq_outcome outcomes_due [$];
    int           mismatch_count = 0;

    assign o_mismatch_count = mismatch_count;

    initial begin
        foreach (ring_words[i]) begin
            ring_words[i] = '0;
        end
    end

    // Apply one operation to the shadow deque and report what the block must show
    task automatic apply_deque_op(input t_op op, input t_word word, output t_deq_outcome res);
        int unsigned slot;
        res.popped = '0;
        res.status = ST_OK;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (word_count >= DEPTH) begin
                    res.status = ST_OVERFLOW;
                end else if (op == OP_PUSH_FRONT) begin
                    front_idx = (front_idx + DEPTH - 1) % DEPTH;
                    ring_words[front_idx] = word;
                    word_count++;
                end else begin
                    ring_words[(front_idx + word_count) % DEPTH] = word;
                    word_count++;
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (word_count == 0) begin
                    res.status = ST_UNDERFLOW;
                end else if (op == OP_POP_FRONT) begin
                    res.popped = ring_words[front_idx];
                    front_idx = (front_idx + 1) % DEPTH;
                    word_count--;
                end else begin
                    slot = (front_idx + word_count - 1) % DEPTH;
                    res.popped = ring_words[slot];
                    word_count--;
                end
            end
            default: begin
                // no operation and the spare codes leave the deque alone
            end
        endcase
        if (word_count == 0) begin
            res.front = '1;
            res.rear  = '1;
            res.empty = 1'b1;
        end else begin
            res.front = ring_words[front_idx];
            res.rear  = ring_words[(front_idx + word_count - 1) % DEPTH];
            res.empty = 1'b0;
        end
        res.count = t_cnt'(word_count);
    endtask

    task automatic check_field(input string field, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    // Drain result words first, then record the operation taken at this edge
    always @(posedge i_clk) begin
        t_deq_outcome want;
        t_deq_outcome next_outcome;
        if (!i_rst_n) begin
            front_idx  = 0;
            word_count = 0;
            outcomes_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (outcomes_due.size() == 0) begin
                    $error("result word with no operation pending");
                    mismatch_count++;
                end else begin
                    want = outcomes_due.pop_front();
                    check_field("popped_value", want.popped, i_popped_value);
                    check_field("front_value", want.front, i_front_value);
                    check_field("rear_value", want.rear, i_rear_value);
                    check_field("item_count", want.count, i_item_count);
                    check_field("is_empty", want.empty, i_is_empty);
                    check_field("status", want.status, i_status);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                apply_deque_op(i_operation, i_data_in, next_outcome);
                outcomes_due.push_back(next_outcome);
            end
        end
        o_pending <= outcomes_due.size();
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives operations into the double-ended queue: a directed pass over empty
// and full edges, extreme words, each push and pop code, then biased random
// traffic that swings the deque between empty and full. Both sides idle and
// stall at random; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    import deq_pkg::*;

    localparam int NUM_WORK_ITEMS = 1900;

    logic    clk       = 1'b0;
    logic    rst_n     = 1'b0;
    logic    in_valid  = 1'b0;
    t_op     operation = OP_NONE;
    t_word   data_in   = '0;
    logic    out_stall = 1'b0;
    logic    in_stall;
    logic    out_valid;
    t_word   popped_value;
    t_word   front_value;
    t_word   rear_value;
    t_cnt    item_count;
    logic    is_empty;
    t_status status;
    int      mismatches;
    int      pending;

    // Shared between the sender and the receiver process
    bit quiet_stretch = 1'b0;
    bit hold_wanted   = 1'b0;

    double_ended_queue i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_operation    (operation),
        .i_data_in      (data_in),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_popped_value (popped_value),
        .o_front_value  (front_value),
        .o_rear_value   (rear_value),
        .o_item_count   (item_count),
        .o_is_empty     (is_empty),
        .o_status       (status)
    );

    deq_checker i_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_operation      (operation),
        .i_data_in        (data_in),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_popped_value   (popped_value),
        .i_front_value    (front_value),
        .i_rear_value     (rear_value),
        .i_item_count     (item_count),
        .i_is_empty       (is_empty),
        .i_status         (status),
        .o_mismatch_count (mismatches),
        .o_pending        (pending)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #4_800_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Offer one word and hold it until the block takes it
    task automatic send_op(input t_op op, input t_word word);
        in_valid  <= 1'b1;
        operation <= op;
        data_in   <= word;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
    endtask

    // Drop valid at random after a word was taken
    task automatic maybe_idle();
        if (!quiet_stretch && $urandom_range(99) < 23) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(2, 1)) @(posedge clk);
        end
    endtask

    // Pause the sender until every result word has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
    endtask

    // Receiver: random stalls, one long hold on request, quiet stretches
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_wanted) begin
                hold_wanted = 1'b0;
                hold_left   = 120;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else if (quiet_stretch) begin
                out_stall <= 1'b0;
            end else begin
                out_stall <= ($urandom_range(99) < 23);
            end
        end
    end

    // Sender: directed edges, then biased random traffic
    initial begin
        t_op         op;
        t_word       word;
        int unsigned work_items;
        int unsigned item_no;
        int unsigned mode;
        int unsigned bias;
        int unsigned k;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty deque: both pops underflow, a spare code does nothing
        send_op(OP_POP_FRONT, 32'sh1234_5678);
        send_op(OP_POP_BACK, 32'sh0BAD_F00D);
        send_op(t_op'(3'd7), 32'sh7654_3210);
        // Extreme words; the second pop removes the last word
        send_op(OP_PUSH_FRONT, 32'sh8000_0000);
        send_op(OP_PUSH_BACK, 32'sh7FFF_FFFF);
        send_op(OP_POP_BACK, '0);
        send_op(OP_POP_FRONT, '0);
        // Word that looks like the empty marker, then fill to the brim
        send_op(OP_PUSH_FRONT, '1);
        for (k = 0; k < DEPTH - 1; k++) begin
            word = t_word'(32'h0101_0101 * (k + 1)) ^ t_word'(k << 28);
            send_op((k % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK, word);
            maybe_idle();
        end
        // Full deque: both pushes overflow
        send_op(OP_PUSH_BACK, 32'sh5555_AAAA);
        send_op(OP_PUSH_FRONT, 32'shAAAA_5555);
        wait_drained();

        work_items = 0;
        item_no    = 0;
        mode       = 2;
        while (work_items < NUM_WORK_ITEMS) begin
            // Pick a new drift now and then so the deque swings end to end
            if (item_no % 40 == 0) begin
                mode = $urandom_range(2);
            end
            bias = (mode == 0) ? 75 : ((mode == 1) ? 25 : 50);

            if ($urandom_range(15) == 0) begin
                case ($urandom_range(3))
                    0:       word = 32'sh8000_0000;
                    1:       word = 32'sh7FFF_FFFF;
                    2:       word = '1;
                    default: word = '0;
                endcase
            end else begin
                word = t_word'($urandom);
            end

            if ($urandom_range(99) < 5) begin
                k  = $urandom_range(3);
                op = (k == 0) ? OP_NONE : t_op'(OP_POP_BACK + k);
            end else begin
                if ($urandom_range(99) < bias) begin
                    op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
                end else begin
                    op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
                end
                work_items++;
            end

            // Phase controls: long receiver hold, pause, quiet stretch
            if (work_items == 300 && item_no > 0) begin
                hold_wanted = 1'b1;
            end
            if (work_items == 1200 && op != OP_NONE) begin
                wait_drained();
            end
            quiet_stretch = (work_items >= 700 && work_items < 1000);

            send_op(op, word);
            maybe_idle();
            item_no++;
        end
        quiet_stretch = 1'b0;

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/deq_pkg.sv
rtl/core/deq_ram.sv
rtl/core/double_ended_queue.sv
rtl/core/deq_checker.sv
tb/deq_checker.sv
tb/tb_top.sv
